@@ src/packed_weight_dequantizer_macros.svh @@
// Assertion macros shared by the dequantizer RTL.
// Depends on nothing; included inside module bodies.
`ifndef PACKED_WEIGHT_DEQUANTIZER_MACROS_SVH
`define PACKED_WEIGHT_DEQUANTIZER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PWD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ src/pwd_pkg.sv @@
// Package of the packed weight dequantizer: types, constants and field helpers.
// Depends on nothing.
`default_nettype none
package pwd_pkg;
    localparam int WORD_BITS = 32;
    localparam logic [1:0] MODE_2B = 2'd0;
    localparam logic [1:0] MODE_4B = 2'd1;
    localparam logic [1:0] MODE_8B = 2'd2;
    // Unused encoding, treated like 8-bit fields.
    localparam logic [1:0] MODE_RSVD = 2'd3;

    // Last field index of a word for a mode.
    function automatic logic [3:0] last_index(input logic [1:0] mode);
        case (mode)
            MODE_2B: last_index = 4'd15;
            MODE_4B: last_index = 4'd7;
            default: last_index = 4'd3;
        endcase
    endfunction

    // Field idx of a packed word for a mode, zero extended to 8 bits.
    function automatic logic [7:0] get_field(input logic [31:0] w, input logic [1:0] mode,
                                             input logic [3:0] idx);
        logic [31:0] sh;
        sh = 32'd0;
        case (mode)
            MODE_2B: begin
                sh = w >> {idx, 1'b0};
                get_field = {6'd0, sh[1:0]};
            end
            MODE_4B: begin
                sh = w >> {idx[2:0], 2'b0};
                get_field = {4'd0, sh[3:0]};
            end
            default: begin
                sh = w >> {idx[1:0], 3'b0};
                get_field = sh[7:0];
            end
        endcase
    endfunction

    // Operand bundle handed from the unpacker to the multiplier.
    typedef struct packed {
        logic [15:0] scale;
        logic        neg;
        logic [8:0]  mag;
        logic [3:0]  row;
        logic        last;
    } t_op;
endpackage
`default_nettype wire

@@ src/pwd_mul.sv @@
// Pipelined half-precision scale times small integer, round to nearest even.
// Depends on pwd_pkg and the macros header. Three register stages, stall by i_en.
`default_nettype none
module pwd_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire pwd_pkg::t_op i_op,
    output logic             o_valid,
    output logic [15:0]      o_half,
    output logic [3:0]       o_row,
    output logic             o_last
);
    import pwd_pkg::*;
    `include "packed_weight_dequantizer_macros.svh"

    // Stage 1: classify, form mantissa and exponent, multiply.
    logic        r_s1_v, r_s1_spec, r_s1_sign, r_s1_last;
    logic [15:0] r_s1_spec_val;
    logic [19:0] r_s1_prod;
    logic signed [6:0] r_s1_e;
    logic [3:0]  r_s1_row;
    logic        n_s1_spec, n_s1_sign;
    logic [15:0] n_s1_spec_val;
    logic [10:0] n_s1_m;
    logic signed [6:0] n_s1_e;
    always_comb begin
        n_s1_sign = i_op.scale[15] ^ i_op.neg;
        n_s1_spec = 1'b1;
        n_s1_spec_val = 16'd0;
        n_s1_m = {1'b1, i_op.scale[9:0]};
        n_s1_e = $signed({2'b0, i_op.scale[14:10]}) - 7'sd25;
        if (i_op.scale[14:10] == 5'd31) begin
            if (i_op.scale[9:0] != 10'd0) n_s1_spec_val = i_op.scale | 16'h0200;
            else if (i_op.mag == 9'd0) n_s1_spec_val = 16'h7E00;
            else n_s1_spec_val = {n_s1_sign, 15'h7C00};
        end else if (i_op.mag == 9'd0 || i_op.scale[14:0] == 15'd0) begin
            n_s1_spec_val = {n_s1_sign, 15'd0};
        end else begin
            n_s1_spec = 1'b0;
            if (i_op.scale[14:10] == 5'd0) begin
                n_s1_m = {1'b0, i_op.scale[9:0]};
                n_s1_e = -7'sd24;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_v <= 1'b0;
        else if (i_en) r_s1_v <= i_valid;
        if (i_en) begin
            r_s1_spec <= n_s1_spec;
            r_s1_spec_val <= n_s1_spec_val;
            r_s1_sign <= n_s1_sign;
            r_s1_prod <= 20'(n_s1_m) * 20'(i_op.mag);
            r_s1_e <= n_s1_e;
            r_s1_row <= i_op.row;
            r_s1_last <= i_op.last;
        end
    end

    // Stage 2: leading one search and shift amount.
    logic        r_s2_v, r_s2_spec, r_s2_sign, r_s2_last, r_s2_ovf;
    logic [15:0] r_s2_spec_val;
    logic [19:0] r_s2_prod;
    logic signed [7:0] r_s2_q, r_s2_s;
    logic [3:0]  r_s2_row;
    logic [4:0]  n_s2_h;
    logic signed [7:0] n_s2_q;
    always_comb begin
        n_s2_h = 5'd0;
        for (int k = 0; k < 20; k++)
            if (r_s1_prod[k]) n_s2_h = 5'(k);
        n_s2_q = $signed({3'b0, n_s2_h}) + 8'(r_s1_e) - 8'sd10;
        if (n_s2_q < -8'sd24) n_s2_q = -8'sd24;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_v <= 1'b0;
        else if (i_en) r_s2_v <= r_s1_v;
        if (i_en) begin
            r_s2_spec <= r_s1_spec;
            r_s2_spec_val <= r_s1_spec_val;
            r_s2_sign <= r_s1_sign;
            r_s2_prod <= r_s1_prod;
            r_s2_q <= n_s2_q;
            r_s2_s <= n_s2_q - 8'(r_s1_e);
            r_s2_ovf <= ($signed({3'b0, n_s2_h}) + 8'(r_s1_e)) >= 8'sd16;
            r_s2_row <= r_s1_row;
            r_s2_last <= r_s1_last;
        end
    end

    // Stage 3: shift, round to nearest even, pack.
    logic        r_s3_v, r_s3_last;
    logic [15:0] r_s3_half;
    logic [3:0]  r_s3_row;
    logic [15:0] n_s3_half;
    logic [20:0] n_s3_mant;
    logic [19:0] n_s3_rem, n_s3_hb, n_s3_mask;
    logic [4:0]  n_s3_sh;
    logic [15:0] n_s3_bits;
    always_comb begin
        n_s3_sh = r_s2_s[4:0];
        n_s3_mask = 20'd0;
        n_s3_hb = 20'd0;
        n_s3_rem = 20'd0;
        if (r_s2_s <= 8'sd0) begin
            n_s3_mant = {1'b0, r_s2_prod} << (5'd0 - n_s3_sh);
        end else if (r_s2_s >= 8'sd21) begin
            n_s3_mant = 21'd0;
        end else begin
            n_s3_mask = (20'd1 << n_s3_sh) - 20'd1;
            n_s3_hb = 20'd1 << (n_s3_sh - 5'd1);
            n_s3_rem = r_s2_prod & n_s3_mask;
            n_s3_mant = {1'b0, r_s2_prod >> n_s3_sh};
            if (n_s3_rem > n_s3_hb || (n_s3_rem == n_s3_hb && n_s3_mant[0]))
                n_s3_mant = n_s3_mant + 21'd1;
        end
        n_s3_bits = {r_s2_q[5:0] + 6'd24, 10'd0} + n_s3_mant[15:0];
        if (n_s3_bits >= 16'h7C00) n_s3_bits = 16'h7C00;
        if (r_s2_spec) n_s3_half = r_s2_spec_val;
        else if (r_s2_ovf) n_s3_half = {r_s2_sign, 15'h7C00};
        else n_s3_half = {r_s2_sign, n_s3_bits[14:0]};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_v <= 1'b0;
        else if (i_en) r_s3_v <= r_s2_v;
        if (i_en) begin
            r_s3_half <= n_s3_half;
            r_s3_row <= r_s2_row;
            r_s3_last <= r_s2_last;
        end
    end
    assign o_valid = r_s3_v;
    assign o_half = r_s3_half;
    assign o_row = r_s3_row;
    assign o_last = r_s3_last;

    `PWD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !i_en, r_s3_v == $past(r_s3_v))
    `PWD_ASSERT_NEXT(a_flow, i_clk, i_rst_n, i_en, r_s3_v == $past(r_s2_v))
    `PWD_ASSERT_IMPL(a_nan_quiet, i_clk, i_rst_n,
        r_s3_v && r_s3_half[14:10] == 5'd31 && r_s3_half[9:0] != 10'd0, r_s3_half[9])
endmodule
`default_nettype wire

@@ src/packed_weight_dequantizer.sv @@
// Top level of the packed weight dequantizer: unpacker, multiplier pipe, output register.
// Depends on pwd_pkg, pwd_mul and the macros header.
//
// Usage: one transaction on s_axis carries a packed 32-bit weight word, the
// group's packed zero word, the column's zero lane and the fp16 scale. The block
// emits 16, 8 or 4 transactions on m_axis (2-, 4- or 8-bit fields), lowest field
// first, tlast on the final one; tuser carries the row offset.
// Throughput: one result per cycle unless m_axis_tready holds the pipe; the
// unpacker's field counter steps through the fields of a word. The next word
// is accepted at the same edge at which the last field of the current word
// enters the multiplier, so words follow with no gap.
// Path of a result: the held word register, the three multiplier stages and
// the output register.
// i_cfg_valid/o_cfg_ready write bit_mode (reset 1, 4-bit); o_cfg_ready is always
// high; write only while idle.
// Reset (synchronous, active low) empties the pipe and restores bit_mode.
// When a result waits in the output register and m_axis_tready is low, the
// whole pipe holds; nothing is lost or repeated.
`default_nettype none
module packed_weight_dequantizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] weight_word, [63:32] zero_word, [67:64] zero_lane, [83:68] scale_bits
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] weight_half
    output logic [15:0]      m_axis_tdata,
    // [3:0] row_offset
    output logic [3:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data
);
    import pwd_pkg::*;
    `include "packed_weight_dequantizer_macros.svh"

    logic [1:0] r_mode;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= MODE_4B;
        else if (i_cfg_valid) r_mode <= i_cfg_data;
    end

    // Pipe advances unless the output register holds an unaccepted result.
    logic en;
    logic mul_v;
    assign en = !m_axis_tvalid || m_axis_tready;

    // Held word and field counter.
    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [31:0] r_word;
    logic [8:0]  r_zero;
    logic [15:0] r_scale;
    logic [3:0]  lane;
    logic        take, fin;
    assign s_axis_tready = en && (!r_busy || fin);
    assign take = s_axis_tvalid && s_axis_tready;
    assign fin = r_busy && r_cnt == last_index(r_mode);
    always_comb begin
        case (r_mode)
            MODE_2B: lane = s_axis_tdata[67:64];
            MODE_4B: lane = {1'b0, s_axis_tdata[66:64]};
            default: lane = {2'b0, s_axis_tdata[65:64]};
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 4'd0;
        end else if (en) begin
            if (take) begin
                r_busy <= 1'b1;
                r_cnt <= 4'd0;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
            end
        end
        if (take) begin
            r_word <= s_axis_tdata[31:0];
            r_zero <= {1'b0, get_field(s_axis_tdata[63:32], r_mode, lane)} + 9'd1;
            r_scale <= s_axis_tdata[83:68];
        end
    end

    // Operand for the current field.
    t_op op;
    logic [8:0] q;
    always_comb begin
        q = {1'b0, get_field(r_word, r_mode, r_cnt)};
        op.scale = r_scale;
        op.neg = q < r_zero;
        op.mag = op.neg ? r_zero - q : q - r_zero;
        op.row = r_cnt;
        op.last = fin;
    end

    logic [15:0] mul_half;
    logic [3:0]  mul_row;
    logic        mul_last;
    pwd_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_busy), .i_op(op),
        .o_valid(mul_v), .o_half(mul_half), .o_row(mul_row), .o_last(mul_last)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (en) m_axis_tvalid <= mul_v;
        if (en) begin
            m_axis_tdata <= mul_half;
            m_axis_tuser <= mul_row;
            m_axis_tlast <= mul_last;
        end
    end

    `PWD_ASSERT_IMPL(a_no_take_midword, i_clk, i_rst_n, r_busy && !fin, !s_axis_tready)
    `PWD_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, r_busy, r_cnt <= last_index(r_mode))
    `PWD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire
